FILE: rtl/tsp_pkg.sv
// Shared types, constants and the divider step for the trapezoid step period block.
package tsp_pkg;

   localparam int PERIOD_W   = 16;
   localparam int INDEX_W    = 24;
   localparam int PROD_W     = 2 * PERIOD_W;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;
   localparam int DIV_STEP   = 2;
   localparam int DIV_STAGES = PERIOD_W / DIV_STEP;

   localparam logic [PERIOD_W-1:0] START_PERIOD_RESET = 16'd4999;
   localparam logic [PERIOD_W-1:0] RUN_PERIOD_RESET   = 16'd1999;
   localparam logic [PERIOD_W-1:0] RAMP_STEPS_RESET   = 16'd80;

   typedef enum logic [1:0] {
      REG_START_PERIOD = 2'd0,
      REG_RUN_PERIOD   = 2'd1,
      REG_RAMP_STEPS   = 2'd2,
      REG_NONE         = 2'd3
   } tsp_reg_type;

   typedef enum logic [1:0] {
      KIND_START,
      KIND_UP,
      KIND_DOWN,
      KIND_RUN
   } tsp_kind_type;

   typedef struct packed {
      logic [PERIOD_W-1:0] start_period;
      logic [PERIOD_W-1:0] run_period;
      logic [PERIOD_W-1:0] ramp_steps;
   } tsp_cfg_type;

   typedef struct packed {
      tsp_kind_type        kind;
      logic [PERIOD_W-1:0] divisor;
      logic [PROD_W-1:0]   numer;
   } tsp_front_out_type;

   // rem stays below divisor; lo shifts numerator bits out and quotient bits in
   typedef struct packed {
      tsp_kind_type        kind;
      logic [PERIOD_W-1:0] divisor;
      logic [PERIOD_W-1:0] rem;
      logic [PERIOD_W-1:0] lo;
   } tsp_dstate_type;

   function automatic tsp_dstate_type div_step(tsp_dstate_type s);
      tsp_dstate_type      r;
      logic [PERIOD_W:0]   trial;
      logic                qbit;
      r     = s;
      trial = {s.rem, s.lo[PERIOD_W-1]};
      qbit  = 1'b0;
      if (trial >= {1'b0, s.divisor}) begin
         trial = trial - {1'b0, s.divisor};
         qbit  = 1'b1;
      end
      r.rem = trial[PERIOD_W-1:0];
      r.lo  = {s.lo[PERIOD_W-2:0], qbit};
      return r;
   endfunction

endpackage

FILE: rtl/tsp_csr.sv
// Configuration registers behind the APB-style port.
module tsp_csr import tsp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output tsp_cfg_type           cfg
);

   tsp_cfg_type cfg_ff, cfg_in;
   tsp_reg_type reg_sel;
   logic        wr_en;

   assign reg_sel    = tsp_reg_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_START_PERIOD: cfg_in.start_period = csr_pwdata[PERIOD_W-1:0];
            REG_RUN_PERIOD:   cfg_in.run_period   = csr_pwdata[PERIOD_W-1:0];
            REG_RAMP_STEPS:   cfg_in.ramp_steps   = csr_pwdata[PERIOD_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_START_PERIOD: csr_prdata = {{(CSR_DATA_W-PERIOD_W){1'b0}}, cfg_ff.start_period};
         REG_RUN_PERIOD:   csr_prdata = {{(CSR_DATA_W-PERIOD_W){1'b0}}, cfg_ff.run_period};
         REG_RAMP_STEPS:   csr_prdata = {{(CSR_DATA_W-PERIOD_W){1'b0}}, cfg_ff.ramp_steps};
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_period <= START_PERIOD_RESET;
         cfg_ff.run_period   <= RUN_PERIOD_RESET;
         cfg_ff.ramp_steps   <= RAMP_STEPS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: rtl/tsp_front.sv
// Front stages: ramp length, segment select, numerator product.
module tsp_front import tsp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  tsp_cfg_type        cfg,
   input  logic               in_valid,
   input  logic [INDEX_W-1:0] in_step_index,
   input  logic [INDEX_W-1:0] in_move_steps,
   output logic               out_valid,
   output tsp_front_out_type  out_data
);

   // stage 1
   logic                s1_valid_ff, s1_valid_in;
   logic [INDEX_W-1:0]  s1_idx_ff, s1_idx_in;
   logic [INDEX_W-1:0]  s1_total_ff, s1_total_in;
   logic [PERIOD_W-1:0] s1_rlen_ff, s1_rlen_in;
   logic                s1_force_ff, s1_force_in;
   // stage 2
   logic                s2_valid_ff;
   logic [INDEX_W-1:0]  s2_idx_ff, s2_idx_in;
   logic [INDEX_W-1:0]  s2_dstart_ff, s2_dstart_in;
   logic [PERIOD_W-1:0] s2_div_ff, s2_div_in;
   logic                s2_up_ff, s2_up_in;
   logic                s2_force_ff;
   // stage 3
   logic                s3_valid_ff;
   tsp_kind_type        s3_kind_ff, s3_kind_in;
   logic [PERIOD_W-1:0] s3_n_ff, s3_n_in;
   logic [PERIOD_W-1:0] s3_div_ff;
   // stage 4
   logic                s4_valid_ff;
   tsp_front_out_type   s4_ff, s4_in;

   logic [INDEX_W-1:0]  diff;
   logic [PERIOD_W-1:0] span;

   // stage 1: ramp length is cut to half the move on short moves
   always_comb begin
      s1_valid_in = in_valid;
      s1_idx_in   = in_step_index;
      s1_total_in = in_move_steps;
      if ({{(INDEX_W-PERIOD_W-1){1'b0}}, cfg.ramp_steps, 1'b0} > in_move_steps)
         s1_rlen_in = in_move_steps[PERIOD_W:1];
      else
         s1_rlen_in = cfg.ramp_steps;
      s1_force_in = (in_move_steps <= INDEX_W'(1)) ||
                    (cfg.run_period > cfg.start_period) ||
                    (s1_rlen_in == '0);
   end

   // stage 2
   always_comb begin
      s2_idx_in    = s1_idx_ff;
      s2_div_in    = (s1_rlen_ff <= PERIOD_W'(1)) ? PERIOD_W'(1) : s1_rlen_ff - PERIOD_W'(1);
      s2_dstart_in = s1_total_ff - {{(INDEX_W-PERIOD_W){1'b0}}, s1_rlen_ff};
      s2_up_in     = s1_idx_ff < {{(INDEX_W-PERIOD_W){1'b0}}, s1_rlen_ff};
   end

   // stage 3: down-ramp offset saturates at the divisor, past it the result is start
   assign diff = s2_idx_ff - s2_dstart_ff;

   always_comb begin
      s3_kind_in = KIND_RUN;
      s3_n_in    = '0;
      if (s2_force_ff) begin
         s3_kind_in = KIND_START;
      end else if (s2_up_ff) begin
         s3_kind_in = KIND_UP;
         s3_n_in    = s2_idx_ff[PERIOD_W-1:0];
      end else if (s2_idx_ff >= s2_dstart_ff) begin
         s3_kind_in = KIND_DOWN;
         if (diff >= {{(INDEX_W-PERIOD_W){1'b0}}, s2_div_ff})
            s3_n_in = s2_div_ff;
         else
            s3_n_in = diff[PERIOD_W-1:0];
      end
   end

   // stage 4
   assign span = cfg.start_period - cfg.run_period;

   always_comb begin
      s4_in.kind    = s3_kind_ff;
      s4_in.divisor = s3_div_ff;
      s4_in.numer   = span * s3_n_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_idx_ff    <= s1_idx_in;
         s1_total_ff  <= s1_total_in;
         s1_rlen_ff   <= s1_rlen_in;
         s1_force_ff  <= s1_force_in;
         s2_idx_ff    <= s2_idx_in;
         s2_dstart_ff <= s2_dstart_in;
         s2_div_ff    <= s2_div_in;
         s2_up_ff     <= s2_up_in;
         s2_force_ff  <= s1_force_ff;
         s3_kind_ff   <= s3_kind_in;
         s3_n_ff      <= s3_n_in;
         s3_div_ff    <= s2_div_ff;
         s4_ff        <= s4_in;
      end
   end

   assign out_valid = s4_valid_ff;
   assign out_data  = s4_ff;

endmodule

FILE: rtl/tsp_div.sv
// Pipelined restoring divider, DIV_STEP quotient bits per stage.
module tsp_div import tsp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  tsp_front_out_type in_data,
   output logic              out_valid,
   output tsp_dstate_type    out_data
);

   logic           valid_ff [DIV_STAGES];
   tsp_dstate_type stage_ff [DIV_STAGES];
   tsp_dstate_type stage_in [DIV_STAGES];
   tsp_dstate_type init;

   // quotient fits PERIOD_W bits, so the high half is already below the divisor
   always_comb begin
      init.kind    = in_data.kind;
      init.divisor = in_data.divisor;
      init.rem     = in_data.numer[PROD_W-1:PERIOD_W];
      init.lo      = in_data.numer[PERIOD_W-1:0];
   end

   always_comb begin
      for (int s = 0; s < DIV_STAGES; s++) begin
         stage_in[s] = (s == 0) ? init : stage_ff[(s == 0) ? 0 : s - 1];
         for (int k = 0; k < DIV_STEP; k++) begin
            stage_in[s] = div_step(stage_in[s]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < DIV_STAGES; s++) valid_ff[s] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= in_valid;
         for (int s = 1; s < DIV_STAGES; s++) valid_ff[s] <= valid_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s < DIV_STAGES; s++) stage_ff[s] <= stage_in[s];
      end
   end

   assign out_valid = valid_ff[DIV_STAGES-1];
   assign out_data  = stage_ff[DIV_STAGES-1];

endmodule

FILE: rtl/trapezoid_step_period.sv
// Trapezoid step period: timer reload period for one step of a stepper move.
//
// Usage:
//   req channel: one beat per step, tdata = {move_steps, step_index}.
//   rsp channel: one beat per request, tdata = period, in request order.
//   csr port: start_period at 0x0, run_period at 0x4, ramp_steps at 0x8;
//   write only while no beat is in flight. pready is tied high.
// Pipeline: a request passes thirteen register stages (four setup/multiply,
//   eight divider, one output) before it can leave on the rsp channel.
// Throughput: one beat per cycle while rsp is not stalled; the sixteen quotient
//   bits are spread over the eight divider stages, two bits each.
// Stall: the whole pipe holds while rsp_tvalid is high and rsp_tready low;
//   req_tready follows, so nothing is dropped or repeated.
// Reset: empties the pipe and loads start_period 4999, run_period 1999,
//   ramp_steps 80.
module trapezoid_step_period import tsp_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [2*INDEX_W-1:0]      req_tdata,   // step_index[23:0], move_steps[47:24]
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [PERIOD_W-1:0]       rsp_tdata,   // period[15:0]
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [CSR_DATA_W-1:0]     csr_pwdata,
   output logic [CSR_DATA_W-1:0]     csr_prdata,
   output logic                      csr_pready
);

   tsp_cfg_type         cfg;
   logic                advance;
   logic                front_valid;
   tsp_front_out_type   front_data;
   logic                div_valid;
   tsp_dstate_type      div_data;
   logic                rsp_valid_ff;
   logic [PERIOD_W-1:0] rsp_data_ff, rsp_data_in;
   logic [PERIOD_W:0]   cand;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   tsp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tsp_front u_front (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .cfg            (cfg),
      .in_valid       (req_tvalid),
      .in_step_index  (req_tdata[INDEX_W-1:0]),
      .in_move_steps  (req_tdata[2*INDEX_W-1:INDEX_W]),
      .out_valid      (front_valid),
      .out_data       (front_data)
   );

   tsp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (front_valid),
      .in_data   (front_data),
      .out_valid (div_valid),
      .out_data  (div_data)
   );

   // quotient never exceeds start - run, so neither branch wraps
   always_comb begin
      case (div_data.kind)
         KIND_UP:   cand = {1'b0, cfg.start_period - div_data.lo};
         KIND_DOWN: cand = {1'b0, cfg.run_period} + {1'b0, div_data.lo};
         KIND_RUN:  cand = {1'b0, cfg.run_period};
         default:   cand = {1'b0, cfg.start_period};
      endcase
      if (cand < {1'b0, cfg.run_period})
         cand = {1'b0, cfg.run_period};
      if (cand > {1'b0, cfg.start_period})
         cand = {1'b0, cfg.start_period};
      rsp_data_in = cand[PERIOD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input accepted while output stalled");

   a_period_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (cfg.run_period <= cfg.start_period) |->
         (rsp_tdata >= cfg.run_period) && (rsp_tdata <= cfg.start_period))
      else $error("period outside run..start range");

   a_div_remainder: assert property (@(posedge clock) disable iff (reset)
      div_valid |-> div_data.rem < div_data.divisor)
      else $error("divider remainder not below divisor");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      front_valid |-> front_data.divisor != '0)
      else $error("zero divisor reached divider");

endmodule
